// ===== hw/rtl/efa_pkg.sv =====
package efa_pkg;

	localparam int FRAME_SIDE  = 128;
	localparam int PIXEL_COUNT = FRAME_SIDE * FRAME_SIDE;
	localparam int ADDR_W      = $clog2(PIXEL_COUNT);
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int COORD_W     = 7;
	localparam int MODE_W      = 2;
	localparam int REG_IDX_W   = 3;

	localparam logic [MODE_W-1:0] MODE_EVENT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DECAY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_ON_RED     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ON_GREEN   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ON_BLUE    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFF_RED    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OFF_GREEN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OFF_BLUE   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DECAY_STEP = 3'd6;

	typedef logic [CHAN_W-1:0]    chan_t;
	typedef logic [COORD_W-1:0]   coord_t;
	typedef logic [MODE_W-1:0]    mode_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [ADDR_W-1:0]    addr_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	typedef struct packed {
		pixel_t on_color;
		pixel_t off_color;
		chan_t  decay_step;
	} cfg_regs_t;

	typedef struct packed {
		logic   rd_en;
		addr_t  rd_addr;
		logic   wr_en;
		addr_t  wr_addr;
		pixel_t wr_data;
	} ram_cmd_t;

	function automatic chan_t sat_add(input chan_t a, input chan_t b);
		logic [CHAN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
	endfunction

	function automatic chan_t clamp_sub(input chan_t a, input chan_t b);
		return (a > b) ? chan_t'(a - b) : '0;
	endfunction

endpackage

// ===== hw/rtl/efa_req_if.sv =====
interface efa_req_if;
	logic             valid;
	logic             ready;
	efa_pkg::mode_t   mode;
	efa_pkg::coord_t  x_coord;
	efa_pkg::coord_t  y_coord;
	logic             polarity;

	modport source(output valid, mode, x_coord, y_coord, polarity, input ready);
	modport sink(input valid, mode, x_coord, y_coord, polarity, output ready);
endinterface

// ===== hw/rtl/efa_rsp_if.sv =====
interface efa_rsp_if;
	logic           valid;
	logic           ready;
	efa_pkg::chan_t red_level;
	efa_pkg::chan_t green_level;
	efa_pkg::chan_t blue_level;

	modport source(output valid, red_level, green_level, blue_level, input ready);
	modport sink(input valid, red_level, green_level, blue_level, output ready);
endinterface

// ===== hw/rtl/efa_cfg_if.sv =====
interface efa_cfg_if;
	logic              valid;
	logic              ready;
	efa_pkg::reg_idx_t index;
	efa_pkg::chan_t    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/efa_pixel_ram.sv =====
module efa_pixel_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== hw/rtl/efa_cfg_regs.sv =====
module efa_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	efa_cfg_if.sink            cfg,
	output efa_pkg::cfg_regs_t regs
);
	import efa_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.on_color   <= '{red: 8'd255, green: 8'd255, blue: 8'd0};
			regs_q.off_color  <= '{red: 8'd0, green: 8'd0, blue: 8'd255};
			regs_q.decay_step <= 8'd8;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ON_RED:     regs_q.on_color.red    <= cfg.data;
				REG_ON_GREEN:   regs_q.on_color.green  <= cfg.data;
				REG_ON_BLUE:    regs_q.on_color.blue   <= cfg.data;
				REG_OFF_RED:    regs_q.off_color.red   <= cfg.data;
				REG_OFF_GREEN:  regs_q.off_color.green <= cfg.data;
				REG_OFF_BLUE:   regs_q.off_color.blue  <= cfg.data;
				REG_DECAY_STEP: regs_q.decay_step      <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/efa_ctrl.sv =====
module efa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	efa_req_if.sink            pix_req,
	efa_rsp_if.source          pix_rsp,
	input  efa_pkg::cfg_regs_t regs,
	output efa_pkg::ram_cmd_t  ram_cmd,
	input  efa_pkg::pixel_t    ram_rdata
);
	import efa_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVENT,
		ST_DECAY,
		ST_READ
	} state_t;

	localparam addr_t LAST_ADDR = addr_t'(PIXEL_COUNT - 1);

	state_t state_q;
	addr_t  sweep_q;
	addr_t  addr_q;
	logic   pol_q;
	logic   zero_q;
	logic   out_valid_q;
	pixel_t out_q;

	logic   accept;
	logic   in_frame;
	addr_t  req_addr;
	logic   out_load;
	pixel_t color;
	pixel_t evt_pix;
	pixel_t dec_pix;

	assign accept   = pix_req.valid && pix_req.ready;
	assign in_frame = (32'(pix_req.x_coord) < FRAME_SIDE) && (32'(pix_req.y_coord) < FRAME_SIDE);
	assign req_addr = addr_t'(32'(pix_req.y_coord) * FRAME_SIDE + 32'(pix_req.x_coord));
	assign out_load = (state_q == ST_READ) && (!out_valid_q || pix_rsp.ready);
	assign color    = pol_q ? regs.on_color : regs.off_color;

	assign pix_req.ready       = (state_q == ST_IDLE);
	assign pix_rsp.valid       = out_valid_q;
	assign pix_rsp.red_level   = out_q.red;
	assign pix_rsp.green_level = out_q.green;
	assign pix_rsp.blue_level  = out_q.blue;

	always_comb begin
		evt_pix.red   = sat_add(ram_rdata.red, color.red);
		evt_pix.green = sat_add(ram_rdata.green, color.green);
		evt_pix.blue  = sat_add(ram_rdata.blue, color.blue);
		dec_pix.red   = clamp_sub(ram_rdata.red, regs.decay_step);
		dec_pix.green = clamp_sub(ram_rdata.green, regs.decay_step);
		dec_pix.blue  = clamp_sub(ram_rdata.blue, regs.decay_step);
	end

	// read side: item address in idle (address 0 for a decay request), next sweep entry while decaying
	always_comb begin
		ram_cmd.rd_en   = 1'b0;
		ram_cmd.rd_addr = sweep_q + addr_t'(1);
		ram_cmd.wr_en   = 1'b0;
		ram_cmd.wr_addr = sweep_q;
		ram_cmd.wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && pix_req.mode == MODE_DECAY) begin
					ram_cmd.rd_en   = 1'b1;
					ram_cmd.rd_addr = '0;
				end else if (accept && in_frame &&
					(pix_req.mode == MODE_EVENT || pix_req.mode == MODE_READ)) begin
					ram_cmd.rd_en   = 1'b1;
					ram_cmd.rd_addr = req_addr;
				end
			end
			ST_EVENT: begin
				ram_cmd.wr_en   = 1'b1;
				ram_cmd.wr_addr = addr_q;
				ram_cmd.wr_data = evt_pix;
			end
			ST_DECAY: begin
				ram_cmd.rd_en   = (sweep_q != LAST_ADDR);
				ram_cmd.wr_en   = 1'b1;
				ram_cmd.wr_data = dec_pix;
			end
			ST_CLEAR: begin
				ram_cmd.wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
			addr_q      <= '0;
			pol_q       <= 1'b0;
			zero_q      <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= zero_q ? pixel_t'('0) : ram_rdata;
			end else if (pix_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + addr_t'(1);
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					addr_q <= req_addr;
					pol_q  <= pix_req.polarity;
					zero_q <= !in_frame;
					if (accept) begin
						case (pix_req.mode)
							MODE_EVENT: if (in_frame) begin
								state_q <= ST_EVENT;
							end
							MODE_DECAY: begin
								state_q <= ST_DECAY;
								sweep_q <= '0;
							end
							MODE_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_EVENT: state_q <= ST_IDLE;
				ST_DECAY: begin
					sweep_q <= sweep_q + addr_t'(1);
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: if (out_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/event_frame_accumulator_decay.sv =====
// event: read, then saturating add and write back on the single memory port pair
// read: result registered in the memory and then in the output register, held until taken;
// no new item is accepted until it is loaded, which waits while an earlier result is pending
// decay tick: all 16384 pixels, one read and one written back per cycle through the memory
// reset: config registers take their defaults, then a clearing pass over all 16384 pixels zeroes
// the frame store while no item is accepted; config writes are taken throughout
module event_frame_accumulator_decay (
	input logic       clk,
	input logic       arst_n,
	efa_req_if.sink   pix_req,
	efa_rsp_if.source pix_rsp,
	efa_cfg_if.sink   cfg
);
	import efa_pkg::*;

	cfg_regs_t regs;
	ram_cmd_t  ram_cmd;
	pixel_t    ram_rdata;
	logic [PIX_W-1:0] rd_bits;

	assign ram_rdata = pixel_t'(rd_bits);

	efa_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	efa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_req   (pix_req),
		.pix_rsp   (pix_rsp),
		.regs      (regs),
		.ram_cmd   (ram_cmd),
		.ram_rdata (ram_rdata)
	);

	efa_pixel_ram #(
		.DEPTH (PIXEL_COUNT),
		.WIDTH (PIX_W)
	) u_pixel_ram (
		.clk     (clk),
		.rd_en   (ram_cmd.rd_en),
		.rd_addr (ram_cmd.rd_addr),
		.rd_data (rd_bits),
		.wr_en   (ram_cmd.wr_en),
		.wr_addr (ram_cmd.wr_addr),
		.wr_data (PIX_W'(ram_cmd.wr_data))
	);
endmodule

// ===== hw/rtl/efa_checker.sv =====
module efa_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input efa_pkg::mode_t  req_mode,
	input efa_pkg::coord_t req_x,
	input efa_pkg::coord_t req_y,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input efa_pkg::chan_t  rsp_red,
	input efa_pkg::chan_t  rsp_green,
	input efa_pkg::chan_t  rsp_blue
);
	import efa_pkg::*;

	logic req_beat;
	logic req_in_frame;

	assign req_beat     = req_valid && req_ready;
	assign req_in_frame = (32'(req_x) < FRAME_SIDE) && (32'(req_y) < FRAME_SIDE);

	// clearing pass holds off items right after reset
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_ready)
		else $error("item taken during clearing pass");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) &&
			$stable(rsp_green) && $stable(rsp_blue))
		else $error("pending result dropped or changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && req_mode != MODE_READ && !rsp_valid |=> !rsp_valid)
		else $error("result without a read");

	a_event_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && req_mode == MODE_EVENT && req_in_frame |=> !req_ready)
		else $error("item taken during event write back");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && req_mode == MODE_READ && !rsp_valid |-> ##2 rsp_valid)
		else $error("read result late");
endmodule

bind event_frame_accumulator_decay efa_checker u_efa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (pix_req.valid),
	.req_ready (pix_req.ready),
	.req_mode  (pix_req.mode),
	.req_x     (pix_req.x_coord),
	.req_y     (pix_req.y_coord),
	.rsp_valid (pix_rsp.valid),
	.rsp_ready (pix_rsp.ready),
	.rsp_red   (pix_rsp.red_level),
	.rsp_green (pix_rsp.green_level),
	.rsp_blue  (pix_rsp.blue_level)
);
